// ===== design/pti_pkg.sv =====
// Package for the probe time interpolator: widths, item and control types,
// sequencer states and the sample sign-extension helper.
// No dependencies; every other design file imports it.
`default_nettype none

package pti_pkg;

  localparam int NUM_CORNERS     = 8;
  localparam int SAMPLE_WIDTH    = 32;

  localparam int TIME_W          = 32;
  localparam int VAL_W           = 32;
  localparam int FRAC_W          = 16;
  localparam int WEIGHT_W        = 17;
  localparam int SAMPLE_FIELD_W  = 32;
  localparam int NUM_WEIGHT_REGS = 8;
  localparam int CFG_IDX_W       = 4;
  localparam int WREG_IDX_W      = $clog2(NUM_WEIGHT_REGS);

  localparam int SMP_EXT_W = (SAMPLE_WIDTH > SAMPLE_FIELD_W) ? SAMPLE_WIDTH : SAMPLE_FIELD_W;
  localparam int MUL_W     = ((SAMPLE_WIDTH > TIME_W) ? SAMPLE_WIDTH : TIME_W) + 1;
  localparam int PROD_W    = 2 * MUL_W;
  localparam int CNT_W     = $clog2(NUM_CORNERS + 1);
  localparam int IDX_W     = (NUM_CORNERS > 1) ? $clog2(NUM_CORNERS) : 1;
  localparam int ACC_W     = SAMPLE_WIDTH + WEIGHT_W + 1 + CNT_W;
  localparam int NUM_W     = 2 * TIME_W;
  localparam int DIV_ITER  = NUM_W / 2;
  localparam int DIV_CNT_W = $clog2(DIV_ITER + 1);

  typedef logic [TIME_W-1:0]          time_t;
  typedef logic signed [VAL_W-1:0]    value_t;
  typedef logic [WEIGHT_W-1:0]        weight_t;
  typedef logic [CFG_IDX_W-1:0]       cfg_idx_t;
  typedef logic [SAMPLE_FIELD_W-1:0]  sample_field_t;

  typedef struct packed {
    logic          func;
    time_t         field_time;
    time_t         query_time;
    sample_field_t sample0;
    sample_field_t sample1;
    sample_field_t sample2;
    sample_field_t sample3;
    sample_field_t sample4;
    sample_field_t sample5;
    sample_field_t sample6;
    sample_field_t sample7;
  } in_item_t;

  typedef struct packed {
    value_t probe_value;
    logic   saturated;
  } out_item_t;

  typedef struct packed {
    logic signed [MUL_W-1:0] a;
    logic signed [MUL_W-1:0] b;
  } mul_op_t;

  typedef logic signed [PROD_W-1:0] prod_t;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    time_t            den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [NUM_W-1:0] quot;
  } div_rsp_t;

  typedef struct packed {
    value_t value;
    logic   clip;
  } sat_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MAC,
    ST_ROUND,
    ST_CHECK,
    ST_MUL,
    ST_DIV_LOAD,
    ST_DIV_WAIT,
    ST_FINAL,
    ST_EMIT
  } state_t;

  function automatic logic signed [SAMPLE_WIDTH-1:0] sext_sample(input sample_field_t raw);
    logic [SMP_EXT_W-1:0] wide;
    wide = SMP_EXT_W'(raw);
    return signed'(wide[SAMPLE_WIDTH-1:0]);
  endfunction

endpackage

`default_nettype wire

// ===== design/pti_if.sv =====
// Handshake interfaces for the probe time interpolator: input items,
// result items and configuration writes. Depends on pti_pkg.
`default_nettype none

interface pti_in_if;
  import pti_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t item;
  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

interface pti_out_if;
  import pti_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t item;
  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

interface pti_cfg_if;
  import pti_pkg::*;
  logic     valid;
  logic     ready;
  cfg_idx_t index;
  weight_t  data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== design/pti_mul.sv =====
// Shared signed multiplier with a registered product, used for the corner
// products and for the interpolation numerator. Depends on pti_pkg.
`default_nettype none

module pti_mul (
  input  logic             clk,
  input  pti_pkg::mul_op_t op,
  output pti_pkg::prod_t   prod
);
  import pti_pkg::*;

  prod_t prod_r;
  prod_t prod_nxt;

  always_comb begin
    prod_nxt = op.a * op.b;
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

  assign prod = prod_r;

endmodule

`default_nettype wire

// ===== design/pti_div.sv =====
// Radix-4 restoring divider, two quotient bits per cycle, for the
// interpolation quotient. Depends on pti_pkg.
`default_nettype none

module pti_div (
  input  logic              clk,
  input  logic              rst_n,
  input  pti_pkg::div_req_t req,
  output pti_pkg::div_rsp_t rsp
);
  import pti_pkg::*;

  logic [NUM_W-1:0]     num_r, num_nxt;
  time_t                rem_r, rem_nxt;
  time_t                den_r, den_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;

  logic [TIME_W:0]  sh1, sh2;
  logic             ge1, ge2;
  time_t            rem1, rem2;
  logic [NUM_W-1:0] num1, num2;

  always_comb begin
    sh1  = {rem_r, num_r[NUM_W-1]};
    ge1  = sh1 >= {1'b0, den_r};
    rem1 = ge1 ? TIME_W'(sh1 - {1'b0, den_r}) : sh1[TIME_W-1:0];
    num1 = {num_r[NUM_W-2:0], ge1};
    sh2  = {rem1, num1[NUM_W-1]};
    ge2  = sh2 >= {1'b0, den_r};
    rem2 = ge2 ? TIME_W'(sh2 - {1'b0, den_r}) : sh2[TIME_W-1:0];
    num2 = {num1[NUM_W-2:0], ge2};
  end

  always_comb begin
    num_nxt  = num_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      num_nxt  = req.num;
      den_nxt  = req.den;
      rem_nxt  = '0;
      cnt_nxt  = DIV_CNT_W'(DIV_ITER);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      num_nxt = num2;
      rem_nxt = rem2;
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == DIV_CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    num_r <= num_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    cnt_r <= cnt_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quot = num_r;

endmodule

`default_nettype wire

// ===== design/probe_time_interpolator_unit.sv =====
// Flow: resync runs the corner sum, rounds it and emits the result; evaluate with a new timestamp
// runs the corner sum and rounding, then, when the slots hold an earlier distinct time, the
// multiply, the divide and the final add before emitting; evaluate with an unchanged timestamp
// skips the corner sum. The corner sum goes through the single shared multiplier, and the
// radix-4 divider returns the interpolation quotient. One item is in work at a time; the next
// is accepted once the result is loaded into the output register, which waits for a free output.
// Synchronous active-low reset clears the time slots, the weights, the state and the output valid.
`default_nettype none

module probe_time_interpolator_unit (
  input  logic       clk,
  input  logic       rst_n,
  pti_in_if.sink     in_chan,
  pti_out_if.source  out_chan,
  pti_cfg_if.sink    cfg_chan
);
  import pti_pkg::*;

  localparam int RND_W = ACC_W + 1 - FRAC_W;
  localparam int R_W   = VAL_W + 4;
  localparam int Q_W   = VAL_W + 3;
  localparam int SAT_W = (RND_W > R_W) ? RND_W : R_W;
  localparam logic signed [SAT_W-1:0] SAT_HI = SAT_W'(2 ** (VAL_W - 1) - 1);
  localparam logic signed [SAT_W-1:0] SAT_LO = -SAT_HI - 1;
  localparam logic [NUM_W-1:0] Q_LIMIT = NUM_W'(1) << (VAL_W + 2);
  localparam logic [ACC_W:0] ROUND_HALF = (ACC_W + 1)'(1) << (FRAC_W - 1);

  function automatic sat_t sat_val(input logic signed [SAT_W-1:0] v);
    sat_t s;
    s.clip = 1'b0;
    if (v > SAT_HI) begin
      s.value = SAT_HI[VAL_W-1:0];
      s.clip  = 1'b1;
    end else if (v < SAT_LO) begin
      s.value = SAT_LO[VAL_W-1:0];
      s.clip  = 1'b1;
    end else begin
      s.value = v[VAL_W-1:0];
    end
    return s;
  endfunction

  state_t state_r, state_nxt;
  in_item_t item_r, item_nxt;
  weight_t weights_r [NUM_WEIGHT_REGS];
  weight_t weights_nxt [NUM_WEIGHT_REGS];
  time_t older_time_r, older_time_nxt;
  time_t newer_time_r, newer_time_nxt;
  value_t older_sum_r, older_sum_nxt;
  value_t newer_sum_r, newer_sum_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic signed [ACC_W-1:0] acc_r, acc_nxt;
  logic clip_r, clip_nxt;
  time_t mdt_r, mdt_nxt;
  time_t mdv_r, mdv_nxt;
  logic neg_r, neg_nxt;
  time_t dlt_r, dlt_nxt;
  value_t res_r, res_nxt;
  logic out_valid_r, out_valid_nxt;
  out_item_t out_item_r, out_item_nxt;

  sample_field_t raw [NUM_WEIGHT_REGS];
  logic [IDX_W-1:0] idx;
  mul_op_t mul_op;
  prod_t prod;
  div_req_t div_req;
  div_rsp_t div_rsp;

  logic in_acc;
  logic new_time;
  logic has_span;
  logic out_free;
  logic signed [ACC_W:0] biased;
  logic signed [RND_W-1:0] rnd;
  sat_t sum_sat;
  logic signed [TIME_W:0] dt;
  logic signed [VAL_W:0] dv;
  logic [NUM_W-1:0] quot;
  logic signed [R_W-1:0] qs;
  logic signed [R_W-1:0] rsum;
  sat_t fin_sat;

  pti_mul u_mul (
    .clk  (clk),
    .op   (mul_op),
    .prod (prod)
  );

  pti_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign in_chan.ready  = (state_r == ST_IDLE);
  assign cfg_chan.ready = 1'b1;
  assign out_chan.valid = out_valid_r;
  assign out_chan.item  = out_item_r;

  assign in_acc   = in_chan.valid && (state_r == ST_IDLE);
  assign new_time = in_chan.item.func || (in_chan.item.field_time != newer_time_r);
  assign has_span = newer_time_r > older_time_r;
  assign out_free = !out_valid_r || out_chan.ready;

  always_comb begin
    raw[0] = item_r.sample0;
    raw[1] = item_r.sample1;
    raw[2] = item_r.sample2;
    raw[3] = item_r.sample3;
    raw[4] = item_r.sample4;
    raw[5] = item_r.sample5;
    raw[6] = item_r.sample6;
    raw[7] = item_r.sample7;
    idx = (cnt_r < CNT_W'(NUM_CORNERS)) ? cnt_r[IDX_W-1:0] : '0;
  end

  always_comb begin
    biased  = {acc_r[ACC_W-1], acc_r} + signed'(ROUND_HALF);
    rnd     = signed'(biased[ACC_W:FRAC_W]);
    sum_sat = sat_val(SAT_W'(rnd));
    dt      = signed'({1'b0, item_r.query_time}) - signed'({1'b0, older_time_r});
    dv      = signed'({newer_sum_r[VAL_W-1], newer_sum_r})
              - signed'({older_sum_r[VAL_W-1], older_sum_r});
    quot    = div_rsp.quot;
    qs      = signed'(R_W'(quot[Q_W-1:0]));
    rsum    = neg_r ? (R_W'(older_sum_r) - qs) : (R_W'(older_sum_r) + qs);
    fin_sat = sat_val(SAT_W'(rsum));
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = new_time ? ST_MAC : ST_CHECK;
        end
      end
      ST_MAC: begin
        if (cnt_r == CNT_W'(NUM_CORNERS)) begin
          state_nxt = ST_ROUND;
        end
      end
      ST_ROUND: begin
        state_nxt = item_r.func ? ST_EMIT : ST_CHECK;
      end
      ST_CHECK: begin
        state_nxt = has_span ? ST_MUL : ST_EMIT;
      end
      ST_MUL: begin
        state_nxt = ST_DIV_LOAD;
      end
      ST_DIV_LOAD: begin
        state_nxt = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (div_rsp.done) begin
          state_nxt = ST_FINAL;
        end
      end
      ST_FINAL: begin
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    item_nxt       = item_r;
    weights_nxt    = weights_r;
    older_time_nxt = older_time_r;
    newer_time_nxt = newer_time_r;
    older_sum_nxt  = older_sum_r;
    newer_sum_nxt  = newer_sum_r;
    cnt_nxt        = cnt_r;
    acc_nxt        = acc_r;
    clip_nxt       = clip_r;
    mdt_nxt        = mdt_r;
    mdv_nxt        = mdv_r;
    neg_nxt        = neg_r;
    dlt_nxt        = dlt_r;
    res_nxt        = res_r;
    out_valid_nxt  = out_valid_r && !out_chan.ready;
    out_item_nxt   = out_item_r;
    mul_op.a       = MUL_W'(sext_sample(raw[idx]));
    mul_op.b       = signed'(MUL_W'(weights_r[idx]));
    div_req.start  = 1'b0;
    div_req.num    = prod[NUM_W-1:0] + NUM_W'(dlt_r >> 1);
    div_req.den    = dlt_r;

    if (cfg_chan.valid && (cfg_chan.index < CFG_IDX_W'(NUM_WEIGHT_REGS))) begin
      weights_nxt[cfg_chan.index[WREG_IDX_W-1:0]] = cfg_chan.data;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          item_nxt = in_chan.item;
          cnt_nxt  = '0;
          acc_nxt  = '0;
          clip_nxt = 1'b0;
        end
      end
      ST_MAC: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r != '0) begin
          acc_nxt = acc_r + signed'(prod[ACC_W-1:0]);
        end
      end
      ST_ROUND: begin
        clip_nxt = sum_sat.clip;
        if (item_r.func) begin
          older_sum_nxt  = sum_sat.value;
          newer_sum_nxt  = sum_sat.value;
          older_time_nxt = item_r.field_time;
          newer_time_nxt = item_r.field_time;
          res_nxt        = sum_sat.value;
        end else begin
          older_sum_nxt  = newer_sum_r;
          older_time_nxt = newer_time_r;
          newer_sum_nxt  = sum_sat.value;
          newer_time_nxt = item_r.field_time;
        end
      end
      ST_CHECK: begin
        mdt_nxt = dt[TIME_W] ? TIME_W'(-dt) : dt[TIME_W-1:0];
        mdv_nxt = dv[VAL_W] ? TIME_W'(-dv) : TIME_W'(dv);
        neg_nxt = dt[TIME_W] ^ dv[VAL_W];
        dlt_nxt = newer_time_r - older_time_r;
        res_nxt = newer_sum_r;
      end
      ST_MUL: begin
        mul_op.a = signed'(MUL_W'(mdt_r));
        mul_op.b = signed'(MUL_W'(mdv_r));
      end
      ST_DIV_LOAD: begin
        div_req.start = 1'b1;
      end
      ST_FINAL: begin
        if (quot > Q_LIMIT) begin
          clip_nxt = 1'b1;
          res_nxt  = neg_r ? SAT_LO[VAL_W-1:0] : SAT_HI[VAL_W-1:0];
        end else begin
          clip_nxt = clip_r | fin_sat.clip;
          res_nxt  = fin_sat.value;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt          = 1'b1;
          out_item_nxt.probe_value = res_r;
          out_item_nxt.saturated   = clip_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_valid_r  <= 1'b0;
      older_time_r <= '0;
      newer_time_r <= '0;
      older_sum_r  <= '0;
      newer_sum_r  <= '0;
      for (int i = 0; i < NUM_WEIGHT_REGS; i++) begin
        weights_r[i] <= '0;
      end
    end else begin
      state_r      <= state_nxt;
      out_valid_r  <= out_valid_nxt;
      older_time_r <= older_time_nxt;
      newer_time_r <= newer_time_nxt;
      older_sum_r  <= older_sum_nxt;
      newer_sum_r  <= newer_sum_nxt;
      weights_r    <= weights_nxt;
    end
    item_r     <= item_nxt;
    cnt_r      <= cnt_nxt;
    acc_r      <= acc_nxt;
    clip_r     <= clip_nxt;
    mdt_r      <= mdt_nxt;
    mdv_r      <= mdv_nxt;
    neg_r      <= neg_nxt;
    dlt_r      <= dlt_nxt;
    res_r      <= res_nxt;
    out_item_r <= out_item_nxt;
  end

endmodule

`default_nettype wire

// ===== design/pti_checker.sv =====
// Port-level checker for the probe time interpolator and the bind that
// attaches it to the top level. Depends on pti_pkg and pti_if.
`default_nettype none

module pti_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input pti_pkg::out_item_t out_item,
  input logic               cfg_valid,
  input logic               cfg_ready
);
  import pti_pkg::*;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while an item is still in work");

  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("reset did not empty the block");

  a_cfg_always_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("configuration write stalled");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("stalled result item changed");

endmodule

bind probe_time_interpolator_unit pti_checker u_pti_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_chan.valid),
  .in_ready  (in_chan.ready),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .out_item  (out_chan.item),
  .cfg_valid (cfg_chan.valid),
  .cfg_ready (cfg_chan.ready)
);

`default_nettype wire

// ===== tb/probe_time_interpolator_unit_tb.sv =====
// Self-checking testbench for probe_time_interpolator_unit: a queue-fed driver that predicts
// each accepted item's probe value, a checking monitor, and random weights and timestamps.
// Depends on pti_pkg, the pti_*_if interfaces and the unit under test.
`timescale 1ns / 1ps

module probe_time_interpolator_unit_tb;
  import pti_pkg::*;

  localparam logic FUNC_EVALUATE = 1'b0;
  localparam logic FUNC_RESYNC   = 1'b1;

  localparam cfg_idx_t REG_WEIGHT_CORNER0 = cfg_idx_t'(0);
  localparam cfg_idx_t REG_UNMAPPED_FIRST = cfg_idx_t'(NUM_WEIGHT_REGS);
  localparam cfg_idx_t REG_UNMAPPED_LAST  = '1;

  localparam int WEIGHTS_ZERO   = 0;
  localparam int WEIGHTS_LSB    = 1;
  localparam int WEIGHTS_UNITY  = 2;
  localparam int WEIGHTS_MAX    = 3;
  localparam int WEIGHTS_SINGLE = 4;
  localparam int WEIGHTS_BLEND  = 5;
  localparam int WEIGHTS_ANY    = 6;

  localparam weight_t       ONE_Q16    = 17'h1_0000;
  localparam sample_field_t SAMPLE_MAX = 32'h7FFF_FFFF;
  localparam sample_field_t SAMPLE_MIN = 32'h8000_0000;
  localparam sample_field_t SAMPLE_ONE = 32'h0001_0000;

  localparam longint          VALUE_MAX      = 64'sd2147483647;
  localparam longint          VALUE_MIN      = -64'sd2147483648;
  localparam longint unsigned QUOTIENT_LIMIT = 64'h4_0000_0000;

  localparam int LONG_STALL_CYCLES = 400;
  localparam int ITEMS_PER_PHASE   = 205;
  localparam int NUM_PHASES        = 8;

  logic clk = 1'b0;
  logic rst_n;

  pti_in_if  in_if ();
  pti_out_if out_if ();
  pti_cfg_if cfg_if ();

  probe_time_interpolator_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .cfg_chan (cfg_if)
  );

  always #5 clk = ~clk;

  in_item_t  probe_query_q [$];
  out_item_t probe_expect_q [$];

  weight_t weight_shadow [NUM_WEIGHT_REGS];
  time_t   slot_old_time;
  time_t   slot_new_time;
  value_t  slot_old_sum;
  value_t  slot_new_sum;

  int    fail_count;
  logic  tx_bursty;
  logic  rx_choppy;
  logic  long_stall_go;
  int    stall_count;
  int    tx_gap_left;
  int    tx_burst_left;
  int    rx_run_left;
  logic  rx_level;
  time_t time_cursor;
  int    sample_level [8];

  function automatic value_t clamp_q16(input longint v, inout logic clip);
    if (v > VALUE_MAX) begin
      clip = 1'b1;
      return value_t'(VALUE_MAX);
    end
    if (v < VALUE_MIN) begin
      clip = 1'b1;
      return value_t'(VALUE_MIN);
    end
    return value_t'(v);
  endfunction

  function automatic value_t corner_sum(input in_item_t it, inout logic clip);
    sample_field_t smp [8];
    longint acc;
    int i;
    smp = '{it.sample0, it.sample1, it.sample2, it.sample3,
            it.sample4, it.sample5, it.sample6, it.sample7};
    acc = 0;
    for (i = 0; i < NUM_CORNERS; i++)
      acc += longint'(signed'(smp[i])) * longint'(weight_shadow[i]);
    return clamp_q16((acc + 64'sd32768) >>> 16, clip);
  endfunction

  function automatic out_item_t predict_probe(input in_item_t it);
    out_item_t res;
    logic clip;
    value_t fresh;
    longint dt, dv, r;
    longint unsigned span, mdt, mdv, quo;
    logic neg;
    clip = 1'b0;
    if (it.func == FUNC_RESYNC) begin
      fresh = corner_sum(it, clip);
      slot_old_sum = fresh;
      slot_new_sum = fresh;
      slot_old_time = it.field_time;
      slot_new_time = it.field_time;
      res.probe_value = fresh;
    end else begin
      if (it.field_time != slot_new_time) begin
        fresh = corner_sum(it, clip);
        slot_old_time = slot_new_time;
        slot_old_sum = slot_new_sum;
        slot_new_time = it.field_time;
        slot_new_sum = fresh;
      end
      if (slot_new_time > slot_old_time) begin
        dt = longint'(it.query_time) - longint'(slot_old_time);
        dv = longint'(slot_new_sum) - longint'(slot_old_sum);
        span = longint'(slot_new_time) - longint'(slot_old_time);
        mdt = (dt < 0) ? -dt : dt;
        mdv = (dv < 0) ? -dv : dv;
        neg = (dt < 0) != (dv < 0);
        quo = (mdt * mdv + span / 2) / span;
        if (quo > QUOTIENT_LIMIT) begin
          clip = 1'b1;
          res.probe_value = neg ? value_t'(VALUE_MIN) : value_t'(VALUE_MAX);
        end else begin
          r = longint'(slot_old_sum) + (neg ? -longint'(quo) : longint'(quo));
          res.probe_value = clamp_q16(r, clip);
        end
      end else begin
        res.probe_value = slot_new_sum;
      end
    end
    res.saturated = clip;
    return res;
  endfunction

  task automatic check_probe_result(input out_item_t got);
    out_item_t want;
    if (probe_expect_q.size() == 0) begin
      $error("probe_value: expected no item, got %0d", got.probe_value);
      fail_count++;
    end else begin
      want = probe_expect_q.pop_front();
      if (got.probe_value !== want.probe_value) begin
        $error("probe_value: expected %0d, got %0d", want.probe_value, got.probe_value);
        fail_count++;
      end
      if (got.saturated !== want.saturated) begin
        $error("saturated: expected %0b, got %0b", want.saturated, got.saturated);
        fail_count++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else if (!in_if.valid || in_if.ready) begin
      if (in_if.valid)
        probe_expect_q.push_back(predict_probe(in_if.item));
      if (tx_gap_left > 0) begin
        tx_gap_left--;
        in_if.valid <= 1'b0;
      end else if (probe_query_q.size() != 0) begin
        in_if.item <= probe_query_q.pop_front();
        in_if.valid <= 1'b1;
        if (tx_bursty) begin
          tx_burst_left--;
          if (tx_burst_left <= 0) begin
            tx_burst_left = $urandom_range(1, 12);
            tx_gap_left = $urandom_range(1, 60);
          end
        end
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (long_stall_go && stall_count < LONG_STALL_CYCLES)
      stall_count <= stall_count + 1;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready)
        check_probe_result(out_if.item);
      if (long_stall_go && stall_count < LONG_STALL_CYCLES) begin
        out_if.ready <= 1'b0;
      end else if (!rx_choppy) begin
        out_if.ready <= 1'b1;
      end else begin
        if (rx_run_left <= 0) begin
          rx_level = ($urandom_range(0, 3) != 0);
          rx_run_left = $urandom_range(1, 8);
        end
        rx_run_left--;
        out_if.ready <= rx_level;
      end
    end
  end

  task automatic write_reg(input cfg_idx_t idx, input weight_t data);
    @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= data;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    if (idx < NUM_WEIGHT_REGS)
      weight_shadow[idx[WREG_IDX_W-1:0]] = data;
    @(negedge clk);
  endtask

  task automatic load_weights(input int style);
    weight_t w;
    int i, hot;
    hot = $urandom_range(0, NUM_WEIGHT_REGS - 1);
    for (i = 0; i < NUM_WEIGHT_REGS; i++) begin
      case (style)
        WEIGHTS_ZERO:   w = '0;
        WEIGHTS_LSB:    w = weight_t'(1);
        WEIGHTS_UNITY:  w = ONE_Q16;
        WEIGHTS_MAX:    w = '1;
        WEIGHTS_SINGLE: w = (i == hot) ? ONE_Q16 : '0;
        WEIGHTS_BLEND:  w = weight_t'($urandom_range(0, ONE_Q16 / 4));
        default:        w = weight_t'($urandom);
      endcase
      write_reg(cfg_idx_t'(REG_WEIGHT_CORNER0 + i), w);
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (probe_query_q.size() != 0 || in_if.valid || probe_expect_q.size() != 0);
  endtask

  function automatic in_item_t probe_query(input logic fn, input time_t ft, input time_t qt,
                                           input sample_field_t first,
                                           input sample_field_t rest);
    return '{fn, ft, qt, first, rest, rest, rest, rest, rest, rest, rest};
  endfunction

  task automatic queue_random_items(input int count);
    sample_field_t smp [8];
    logic fn;
    time_t ft, qt;
    logic wild;
    int n, k, pick;
    for (n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      wild = ($urandom_range(0, 99) < 15);
      fn = FUNC_EVALUATE;
      if (pick < 6) begin
        fn = logic'($urandom_range(0, 1));
        time_cursor = $urandom;
        wild = 1'b1;
      end else if (pick < 12) begin
        fn = FUNC_RESYNC;
        time_cursor = time_cursor + $urandom_range(0, 500);
      end else if (pick < 20) begin
        time_cursor = time_cursor;
      end else if (pick < 24) begin
        time_cursor = time_cursor - $urandom_range(1, 3000);
      end else if (pick < 27) begin
        time_cursor = time_cursor + $urandom;
      end else begin
        time_cursor = time_cursor + $urandom_range(1, 2000);
      end
      ft = time_cursor;
      k = $urandom_range(0, 99);
      if (k < 55) qt = ft - $urandom_range(0, 3000);
      else if (k < 80) qt = ft + $urandom_range(0, 3000);
      else if (k < 92) qt = $urandom;
      else qt = ft;
      for (k = 0; k < 8; k++) begin
        if (pick >= 97) sample_level[k] = $urandom;
        if (wild) begin
          smp[k] = $urandom;
        end else begin
          sample_level[k] = sample_level[k] + int'($urandom_range(0, 131072)) - 65536;
          smp[k] = sample_field_t'(sample_level[k]);
        end
      end
      probe_query_q.push_back('{fn, ft, qt, smp[0], smp[1], smp[2], smp[3],
                                smp[4], smp[5], smp[6], smp[7]});
    end
  endtask

  initial begin
    int p;
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.item = '0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.data = '0;
    fail_count = 0;
    tx_bursty = 1'b1;
    rx_choppy = 1'b1;
    long_stall_go = 1'b0;
    stall_count = 0;
    tx_gap_left = 0;
    tx_burst_left = 1;
    rx_run_left = 0;
    rx_level = 1'b1;
    time_cursor = '0;
    slot_old_time = '0;
    slot_new_time = '0;
    slot_old_sum = '0;
    slot_new_sum = '0;
    for (p = 0; p < NUM_WEIGHT_REGS; p++) weight_shadow[p] = '0;
    for (p = 0; p < 8; p++) sample_level[p] = 0;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Weights are still zero from reset; the first timestamp matches the reset slot.
    probe_query_q.push_back(probe_query(FUNC_EVALUATE, 0, 0, SAMPLE_MAX, SAMPLE_MAX));
    probe_query_q.push_back(probe_query(FUNC_EVALUATE, 100, 50, 32'h1234_5678, SAMPLE_MIN));
    wait_drained();

    write_reg(REG_WEIGHT_CORNER0, ONE_Q16);
    probe_query_q.push_back(probe_query(FUNC_RESYNC, 1000, 1000, SAMPLE_ONE, SAMPLE_MAX));
    probe_query_q.push_back(probe_query(FUNC_EVALUATE, 1000, 2000, SAMPLE_MAX, 0));
    probe_query_q.push_back(probe_query(FUNC_EVALUATE, 1010, 1005, 32'h0002_0000, 0));
    probe_query_q.push_back(probe_query(FUNC_EVALUATE, 1020, 1015, 32'h0002_0001, 0));
    probe_query_q.push_back(probe_query(FUNC_EVALUATE, 1030, 1025, 32'h0002_0000, 0));
    probe_query_q.push_back(probe_query(FUNC_EVALUATE, 1040, 0, SAMPLE_MAX, 0));
    probe_query_q.push_back(probe_query(FUNC_EVALUATE, 1050, '1, SAMPLE_MIN, 0));
    probe_query_q.push_back(probe_query(FUNC_EVALUATE, 1060, 1055, SAMPLE_MIN, 0));
    probe_query_q.push_back(probe_query(FUNC_EVALUATE, 500, 700, SAMPLE_ONE, 0));
    probe_query_q.push_back(probe_query(FUNC_EVALUATE, '1, '1, SAMPLE_MAX, 0));
    probe_query_q.push_back(probe_query(FUNC_RESYNC, 0, 0, 32'hFFFF_8000, SAMPLE_MAX));
    wait_drained();

    load_weights(WEIGHTS_UNITY);
    probe_query_q.push_back(probe_query(FUNC_RESYNC, 10, 10, SAMPLE_MAX, SAMPLE_MAX));
    probe_query_q.push_back(probe_query(FUNC_RESYNC, 10, 10, SAMPLE_MIN, SAMPLE_MIN));
    probe_query_q.push_back(probe_query(FUNC_EVALUATE, 20, 15, 32'h1000_0000, 32'h1000_0000));
    wait_drained();

    // Half-LSB sums check rounding of ties on both signs.
    load_weights(WEIGHTS_LSB);
    probe_query_q.push_back(probe_query(FUNC_RESYNC, 0, 0, 32'h0000_8000, 0));
    probe_query_q.push_back(probe_query(FUNC_RESYNC, 0, 0, 32'hFFFF_8000, 0));
    probe_query_q.push_back(probe_query(FUNC_RESYNC, 0, 0, 32'hFFFF_7FFF, 0));
    wait_drained();

    load_weights(WEIGHTS_MAX);
    probe_query_q.push_back(probe_query(FUNC_RESYNC, 3, 3, SAMPLE_MAX, SAMPLE_MAX));
    probe_query_q.push_back(probe_query(FUNC_RESYNC, 3, 3, '1, '1));
    probe_query_q.push_back(probe_query(FUNC_EVALUATE, 5, 9, 32'h5555_5555, 32'hAAAA_AAAA));
    wait_drained();

    // Writes past the last weight register must leave every weight alone.
    write_reg(REG_UNMAPPED_FIRST, '0);
    write_reg(REG_UNMAPPED_LAST, '0);
    probe_query_q.push_back(probe_query(FUNC_RESYNC, 7, 7, SAMPLE_ONE, SAMPLE_ONE));
    wait_drained();

    for (p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0, 3, 7: load_weights(WEIGHTS_BLEND);
        1, 5:    load_weights(WEIGHTS_ANY);
        2:       load_weights(WEIGHTS_SINGLE);
        4:       load_weights(WEIGHTS_UNITY);
        default: load_weights(WEIGHTS_MAX);
      endcase
      write_reg(cfg_idx_t'($urandom_range(REG_UNMAPPED_FIRST, REG_UNMAPPED_LAST)),
                weight_t'($urandom));
      tx_bursty = (p % 2 == 0);
      rx_choppy = (p % 4 < 2);
      if (p == 5) long_stall_go = 1'b1;
      queue_random_items(ITEMS_PER_PHASE);
      wait_drained();
    end

    repeat (64) @(negedge clk);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
